// ----- design/xbc_pkg.sv -----
// shared types and constants for the xtea block cipher unit
package xbc_pkg;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned KEY_WORDS = 4;
   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam int unsigned ROUND_COUNT_DEFAULT = 32;

   localparam logic [WORD_WIDTH-1:0] DELTA = 32'h9E37_79B9;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_0 = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_1 = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_2 = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_3 = 8'd3;

   localparam logic REQ_ENCRYPT = 1'b0;
   localparam logic REQ_DECRYPT = 1'b1;

   typedef logic [KEY_WORDS-1:0][WORD_WIDTH-1:0] key_set_type;

   typedef struct packed {
      logic                  req_type;
      logic [WORD_WIDTH-1:0] first_word;
      logic [WORD_WIDTH-1:0] second_word;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] out_first_word;
      logic [WORD_WIDTH-1:0] out_second_word;
   } rsp_payload_type;

   typedef struct packed {
      logic                  decrypt;
      logic [WORD_WIDTH-1:0] v0;
      logic [WORD_WIDTH-1:0] v1;
   } cell_data_type;

endpackage

// ----- design/xbc_cell.sv -----
// one half-round cell of the xtea chain
module xbc_cell #(
   parameter int unsigned ROUND_COUNT = xbc_pkg::ROUND_COUNT_DEFAULT,
   parameter int unsigned CELL_INDEX  = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  xbc_pkg::cell_data_type in_data,
   input  xbc_pkg::key_set_type  key,
   output logic                  out_valid,
   output xbc_pkg::cell_data_type out_data
);

   localparam int unsigned ENC_STEPS = (CELL_INDEX + 1) / 2;
   localparam logic IS_ODD = ((CELL_INDEX % 2) == 1);
   localparam logic [31:0] ENC_SUM = 32'(ENC_STEPS) * xbc_pkg::DELTA;
   localparam logic [31:0] DEC_SUM = 32'(ROUND_COUNT - ENC_STEPS) * xbc_pkg::DELTA;
   localparam logic [1:0] ENC_KEY_SEL = IS_ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
   localparam logic [1:0] DEC_KEY_SEL = IS_ODD ? DEC_SUM[1:0] : DEC_SUM[12:11];

   logic                   valid_ff;
   logic                   valid_in;
   xbc_pkg::cell_data_type data_ff;
   xbc_pkg::cell_data_type data_in;

   logic        target_is_v0;
   logic [31:0] source_word;
   logic [31:0] target_word;
   logic [31:0] mix_value;
   logic [31:0] key_value;
   logic [31:0] round_value;
   logic [31:0] new_word;

   always_comb begin
      target_is_v0 = IS_ODD ^ in_data.decrypt ? 1'b0 : 1'b1;
      source_word  = target_is_v0 ? in_data.v1 : in_data.v0;
      target_word  = target_is_v0 ? in_data.v0 : in_data.v1;
      mix_value    = ((source_word << 4) ^ (source_word >> 5)) + source_word;
      if (in_data.decrypt == xbc_pkg::REQ_DECRYPT) begin
         key_value = DEC_SUM + key[DEC_KEY_SEL];
      end else begin
         key_value = ENC_SUM + key[ENC_KEY_SEL];
      end
      round_value = mix_value ^ key_value;
      if (in_data.decrypt == xbc_pkg::REQ_DECRYPT) begin
         new_word = target_word - round_value;
      end else begin
         new_word = target_word + round_value;
      end
      data_in.decrypt = in_data.decrypt;
      data_in.v0      = target_is_v0 ? new_word : in_data.v0;
      data_in.v1      = target_is_v0 ? in_data.v1 : new_word;
      valid_in        = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- design/xtea_block_cipher_unit.sv -----
// top level of the xtea block cipher unit: key registers, cell chain, output register
// a request passes through each half-round cell register in turn and then the output register
// throughput: one block per cycle while the chain is not stalled, one half-round cell per pipeline stage
// the chain stalls only when its last cell and the output register are both full and rsp_ready is low
// reset: synchronous, clears all valid flags and the four key words to zero
// csr writes are always accepted; indexes above three are ignored
module xtea_block_cipher_unit #(
   parameter int unsigned ROUND_COUNT = xbc_pkg::ROUND_COUNT_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  xbc_pkg::req_payload_type              req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output xbc_pkg::rsp_payload_type              rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [xbc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [xbc_pkg::WORD_WIDTH-1:0]        csr_data
);

   localparam int unsigned NUM_CELLS = 2 * ROUND_COUNT;

   xbc_pkg::key_set_type     key_ff;
   xbc_pkg::key_set_type     key_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   xbc_pkg::rsp_payload_type rsp_data_ff;
   xbc_pkg::rsp_payload_type rsp_data_in;
   logic                     advance;
   logic                     csr_write;

   logic                   stage_valid [NUM_CELLS+1];
   xbc_pkg::cell_data_type stage_data  [NUM_CELLS+1];

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      key_in = key_ff;
      if (csr_write) begin
         case (csr_index)
            xbc_pkg::CSR_KEY_WORD_0: key_in[0] = csr_data;
            xbc_pkg::CSR_KEY_WORD_1: key_in[1] = csr_data;
            xbc_pkg::CSR_KEY_WORD_2: key_in[2] = csr_data;
            xbc_pkg::CSR_KEY_WORD_3: key_in[3] = csr_data;
            default: key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign advance   = !stage_valid[NUM_CELLS] || !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   assign stage_valid[0]         = req_valid;
   assign stage_data[0].decrypt  = req_payload.req_type;
   assign stage_data[0].v0       = req_payload.first_word;
   assign stage_data[0].v1       = req_payload.second_word;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      xbc_cell #(
         .ROUND_COUNT (ROUND_COUNT),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_data   (stage_data[i]),
         .key       (key_ff),
         .out_valid (stage_valid[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance && stage_valid[NUM_CELLS]) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.out_first_word  = stage_data[NUM_CELLS].v0;
         rsp_data_in.out_second_word = stage_data[NUM_CELLS].v1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef ASSERT_OFF
   a_request_enters_chain: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> stage_valid[1])
      else $error("accepted request did not enter the first cell");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (stage_valid[NUM_CELLS] && rsp_valid_ff && !rsp_ready))
      else $error("chain stalled without a full output register");

   a_key_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index == xbc_pkg::CSR_KEY_WORD_0) |=> (key_ff[0] == $past(csr_data)))
      else $error("key word write lost");

   a_result_not_dropped: assert property (@(posedge clock) disable iff (reset)
      (stage_valid[NUM_CELLS] && !advance) |=> stage_valid[NUM_CELLS])
      else $error("last cell lost a block while stalled");
`endif

endmodule
